>>> hw/rtl/assert_macros.svh
// assertion macros used by the tpsd_parser module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/tpsd_pkg.sv
// types and constants of the tga pixel stream decoder
`timescale 1ns / 1ps
package tpsd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_SKIP_ID  = 3'd1,
    PH_SKIP_MAP = 3'd2,
    PH_RAW      = 3'd3,
    PH_RLE_HDR  = 3'd4,
    PH_RLE_PIX  = 3'd5,
    PH_IDLE     = 3'd6
  } phase_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TYPE    = 2'd1;
  localparam logic [1:0] ERR_DEPTH   = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  localparam logic [7:0] KIND_RAW = 8'd2;
  localparam logic [7:0] KIND_RLE = 8'd10;

  localparam logic [7:0] DEPTH_16 = 8'd16;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_KIND      = 5'd2;
  localparam logic [4:0] HDR_MAP_LEN_L = 5'd5;
  localparam logic [4:0] HDR_MAP_LEN_H = 5'd6;
  localparam logic [4:0] HDR_MAP_BITS  = 5'd7;
  localparam logic [4:0] HDR_WIDTH_L   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_H   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_L  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_H  = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;

  localparam logic [7:0] RLE_REPEAT_MARK = 8'h80;
  localparam logic [7:0] RLE_REPEAT_BIAS = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } byte_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [7:0]  repeat_count;
    logic        last_run;
    logic [1:0]  error_code;
    logic [15:0] width_px;
    logic [15:0] height_px;
  } run_word_t;

endpackage

>>> hw/rtl/tpsd_in_if.sv
// byte input channel
`timescale 1ns / 1ps
interface tpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

>>> hw/rtl/tpsd_out_if.sv
// pixel run output channel
`timescale 1ns / 1ps
interface tpsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        has_alpha;
  logic [7:0]  repeat_count;
  logic        last_run;
  logic [1:0]  error_code;
  logic [15:0] width_px;
  logic [15:0] height_px;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output has_alpha, output repeat_count, output last_run,
                  output error_code, output width_px, output height_px,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input has_alpha, input repeat_count, input last_run,
                input error_code, input width_px, input height_px,
                output ready);
endinterface

>>> hw/rtl/tpsd_in_stage.sv
// input register stage for file bytes
`timescale 1ns / 1ps
module tpsd_in_stage (
  input  logic                clk,
  input  logic                rst,
  tpsd_in_if.sink             byte_in,
  input  logic                step,
  output logic                word_valid,
  output tpsd_pkg::byte_word_t word
);
  import tpsd_pkg::*;

  assign byte_in.ready = !word_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      word_valid <= 1'b1;
    end else if (step) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      word.data_byte  <= byte_in.data_byte;
      word.file_start <= byte_in.file_start;
    end
  end

endmodule

>>> hw/rtl/tpsd_parser.sv
// header parse, skip and pixel decode state with result logic
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tpsd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  tpsd_pkg::byte_word_t word,
  output logic                 res_valid,
  output tpsd_pkg::run_word_t  res
);
  import tpsd_pkg::*;

  phase_t      phase, phase_next;
  logic [4:0]  hidx, hidx_next;
  logic [7:0]  image_kind, image_kind_next;
  logic [7:0]  pixel_depth, pixel_depth_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [15:0] map_length, map_length_next;
  logic [17:0] skip_remaining, skip_remaining_next;
  logic        packet_is_repeat, packet_is_repeat_next;
  logic [7:0]  packet_remaining, packet_remaining_next;
  logic [1:0]  byte_slot, byte_slot_next;
  logic [31:0] pixel_assembly, pixel_assembly_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [4:0]  map_entry_bytes, map_entry_bytes_next;

  phase_t      eff_phase, pix_phase, map_or_pix_phase;
  logic [4:0]  eff_hidx;
  logic [7:0]  b;
  logic [4:0]  bpb;
  logic        pixel_whole;
  logic [31:0] assembled;
  logic [7:0]  px_red, px_green, px_blue, px_alpha;
  logic        depth_32;
  logic [31:0] product, pl_src;
  logic [1:0]  hdr_err;
  logic        map_route;
  logic [17:0] skip_dec;
  logic [15:0] ml_dec;
  logic        rep_over;
  logic [7:0]  run_count;
  logic [31:0] pl_after;
  logic [7:0]  pr_dec;
  logic        run_last;
  logic [1:0]  run_err;
  logic [7:0]  pr_after;

  assign b         = word.data_byte;
  assign eff_phase = word.file_start ? PH_HEADER : phase;
  assign eff_hidx  = word.file_start ? '0 : hidx;
  assign bpb       = pixel_depth[7:3];
  assign depth_32  = (pixel_depth == DEPTH_32);

  assign pixel_whole = !(({3'b000, byte_slot} + 5'd1) < bpb);
  assign assembled   = pixel_assembly | ({24'b0, b} << {byte_slot, 3'b000});

  always_comb begin
    if (pixel_depth == DEPTH_16) begin
      px_blue  = {assembled[4:0], 3'b000};
      px_green = {assembled[9:5], 3'b000};
      px_red   = {assembled[14:10], 3'b000};
      px_alpha = 8'hff;
    end else begin
      px_blue  = assembled[7:0];
      px_green = assembled[15:8];
      px_red   = assembled[23:16];
      px_alpha = depth_32 ? assembled[31:24] : 8'hff;
    end
  end

  assign product = {16'b0, width_reg} * {16'b0, height_reg};

  always_comb begin
    if (!(image_kind inside {KIND_RAW, KIND_RLE})) begin
      hdr_err = ERR_TYPE;
    end else if (!(pixel_depth inside {DEPTH_24, DEPTH_32}) &&
                 !(image_kind == KIND_RAW && pixel_depth == DEPTH_16)) begin
      hdr_err = ERR_DEPTH;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  assign pl_src           = (eff_phase == PH_HEADER) ? product : pixels_left;
  assign pix_phase        = (pl_src == '0) ? PH_IDLE :
                            ((image_kind == KIND_RAW) ? PH_RAW : PH_RLE_HDR);
  assign map_route        = (map_length != '0) && (map_entry_bytes != '0);
  assign map_or_pix_phase = map_route ? PH_SKIP_MAP : pix_phase;
  assign skip_dec         = skip_remaining - 18'd1;
  assign ml_dec           = map_length - 16'd1;

  // run length and overrun
  assign rep_over  = {24'b0, packet_remaining} > pixels_left;
  assign pr_dec    = packet_remaining - 8'd1;
  always_comb begin
    if (eff_phase == PH_RLE_PIX && packet_is_repeat) begin
      run_count = rep_over ? pixels_left[7:0] : packet_remaining;
    end else begin
      run_count = 8'd1;
    end
  end
  assign pl_after = pixels_left - {24'b0, run_count};
  assign run_last = (pl_after == '0);
  always_comb begin
    if (eff_phase != PH_RLE_PIX) begin
      run_err = ERR_NONE;
    end else if (packet_is_repeat) begin
      run_err = rep_over ? ERR_OVERRUN : ERR_NONE;
    end else begin
      run_err = (run_last && pr_dec != '0) ? ERR_OVERRUN : ERR_NONE;
    end
  end
  assign pr_after = packet_is_repeat ? 8'd0 : pr_dec;

  // next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      phase_next = eff_phase;
      case (eff_phase)
        PH_HEADER: begin
          if (!(eff_hidx < HDR_LAST)) begin
            if (hdr_err != ERR_NONE) begin
              phase_next = PH_IDLE;
            end else if (skip_remaining != '0) begin
              phase_next = PH_SKIP_ID;
            end else begin
              phase_next = map_or_pix_phase;
            end
          end
        end
        PH_SKIP_ID: begin
          if (skip_dec == '0) begin
            phase_next = map_or_pix_phase;
          end
        end
        PH_SKIP_MAP: begin
          if (skip_dec == '0 && ml_dec == '0) begin
            phase_next = pix_phase;
          end
        end
        PH_RAW: begin
          if (pixel_whole && run_last) begin
            phase_next = PH_IDLE;
          end
        end
        PH_RLE_HDR: begin
          phase_next = PH_RLE_PIX;
        end
        PH_RLE_PIX: begin
          if (pixel_whole) begin
            if (run_last) begin
              phase_next = PH_IDLE;
            end else if (pr_after == '0) begin
              phase_next = PH_RLE_HDR;
            end
          end
        end
        default: begin
          phase_next = eff_phase;
        end
      endcase
    end
  end

  // datapath next values
  always_comb begin
    hidx_next             = hidx;
    image_kind_next       = image_kind;
    pixel_depth_next      = pixel_depth;
    width_reg_next        = width_reg;
    height_reg_next       = height_reg;
    map_length_next       = map_length;
    skip_remaining_next   = skip_remaining;
    packet_is_repeat_next = packet_is_repeat;
    packet_remaining_next = packet_remaining;
    byte_slot_next        = byte_slot;
    pixel_assembly_next   = pixel_assembly;
    pixels_left_next      = pixels_left;
    map_entry_bytes_next  = map_entry_bytes;
    if (step) begin
      case (eff_phase)
        PH_HEADER: begin
          case (eff_hidx)
            HDR_ID_LEN:    skip_remaining_next = {10'b0, b};
            HDR_KIND:      image_kind_next = b;
            HDR_MAP_LEN_L: map_length_next = {map_length[15:8], b};
            HDR_MAP_LEN_H: map_length_next = {b, map_length[7:0]};
            HDR_MAP_BITS:  map_entry_bytes_next = b[7:3];
            HDR_WIDTH_L:   width_reg_next = {width_reg[15:8], b};
            HDR_WIDTH_H:   width_reg_next = {b, width_reg[7:0]};
            HDR_HEIGHT_L:  height_reg_next = {height_reg[15:8], b};
            HDR_HEIGHT_H:  height_reg_next = {b, height_reg[7:0]};
            HDR_DEPTH:     pixel_depth_next = b;
            default:       hidx_next = hidx_next;
          endcase
          if (eff_hidx < HDR_LAST) begin
            hidx_next = eff_hidx + 5'd1;
          end else begin
            hidx_next = '0;
            if (hdr_err == ERR_NONE) begin
              pixels_left_next = product;
              if (skip_remaining == '0) begin
                if (map_route) begin
                  skip_remaining_next = {13'b0, map_entry_bytes};
                end else begin
                  byte_slot_next      = '0;
                  pixel_assembly_next = '0;
                end
              end
            end
          end
        end
        PH_SKIP_ID: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            if (map_route) begin
              skip_remaining_next = {13'b0, map_entry_bytes};
            end else begin
              byte_slot_next      = '0;
              pixel_assembly_next = '0;
            end
          end
        end
        PH_SKIP_MAP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            map_length_next = ml_dec;
            if (ml_dec != '0) begin
              skip_remaining_next = {13'b0, map_entry_bytes};
            end else begin
              byte_slot_next      = '0;
              pixel_assembly_next = '0;
            end
          end
        end
        PH_RAW, PH_RLE_PIX: begin
          if (!pixel_whole) begin
            byte_slot_next      = byte_slot + 2'd1;
            pixel_assembly_next = assembled;
          end else begin
            byte_slot_next      = '0;
            pixel_assembly_next = '0;
            pixels_left_next    = pl_after;
            if (eff_phase == PH_RLE_PIX) begin
              packet_remaining_next = pr_after;
            end
          end
        end
        PH_RLE_HDR: begin
          if (b < RLE_REPEAT_MARK) begin
            packet_is_repeat_next = 1'b0;
            packet_remaining_next = b + 8'd1;
          end else begin
            packet_is_repeat_next = 1'b1;
            packet_remaining_next = b - RLE_REPEAT_BIAS;
          end
          byte_slot_next      = '0;
          pixel_assembly_next = '0;
        end
        default: begin
          hidx_next = hidx;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res_valid     = 1'b0;
    res           = '0;
    res.width_px  = width_reg;
    res.height_px = height_reg;
    case (eff_phase)
      PH_HEADER: begin
        if (!(eff_hidx < HDR_LAST) && hdr_err != ERR_NONE) begin
          res_valid      = 1'b1;
          res.error_code = hdr_err;
        end
      end
      PH_RAW, PH_RLE_PIX: begin
        if (pixel_whole) begin
          res_valid        = 1'b1;
          res.red          = px_red;
          res.green        = px_green;
          res.blue         = px_blue;
          res.alpha        = px_alpha;
          res.has_alpha    = depth_32;
          res.repeat_count = run_count;
          res.last_run     = run_last;
          res.error_code   = run_err;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      hidx             <= '0;
      image_kind       <= '0;
      pixel_depth      <= '0;
      width_reg        <= '0;
      height_reg       <= '0;
      map_length       <= '0;
      skip_remaining   <= '0;
      packet_is_repeat <= 1'b0;
      packet_remaining <= '0;
      byte_slot        <= '0;
      pixel_assembly   <= '0;
      pixels_left      <= '0;
      map_entry_bytes  <= '0;
    end else begin
      phase            <= phase_next;
      hidx             <= hidx_next;
      image_kind       <= image_kind_next;
      pixel_depth      <= pixel_depth_next;
      width_reg        <= width_reg_next;
      height_reg       <= height_reg_next;
      map_length       <= map_length_next;
      skip_remaining   <= skip_remaining_next;
      packet_is_repeat <= packet_is_repeat_next;
      packet_remaining <= packet_remaining_next;
      byte_slot        <= byte_slot_next;
      pixel_assembly   <= pixel_assembly_next;
      pixels_left      <= pixels_left_next;
      map_entry_bytes  <= map_entry_bytes_next;
    end
  end

  `ASSERT_NEXT(a_last_goes_idle, clk, rst, step && res_valid && res.last_run,
               phase == PH_IDLE, "last run did not idle")
  `ASSERT_IMPLY(a_pixels_pending, clk, rst,
                phase == PH_RAW || phase == PH_RLE_HDR || phase == PH_RLE_PIX,
                pixels_left != '0, "pixel phase with no pixels left")
  `ASSERT_IMPLY(a_slot_in_pixel, clk, rst, phase == PH_RAW || phase == PH_RLE_PIX,
                ({3'b000, byte_slot} < bpb), "byte slot beyond pixel size")

endmodule

>>> hw/rtl/tpsd_out_stage.sv
// result register holding one pixel run word
`timescale 1ns / 1ps
module tpsd_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tpsd_pkg::run_word_t res,
  output logic                free,
  tpsd_out_if.source          run_out
);
  import tpsd_pkg::*;

  run_word_t held;

  assign free = !run_out.valid || run_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_out.valid <= 1'b0;
    end else if (load) begin
      run_out.valid <= 1'b1;
    end else if (run_out.ready) begin
      run_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign run_out.red          = held.red;
  assign run_out.green        = held.green;
  assign run_out.blue         = held.blue;
  assign run_out.alpha        = held.alpha;
  assign run_out.has_alpha    = held.has_alpha;
  assign run_out.repeat_count = held.repeat_count;
  assign run_out.last_run     = held.last_run;
  assign run_out.error_code   = held.error_code;
  assign run_out.width_px     = held.width_px;
  assign run_out.height_px    = held.height_px;

endmodule

>>> hw/rtl/tga_pixel_stream_decoder.sv
// top level of the tga pixel stream decoder
//
//   channel   dir  word
//   byte_in   in   data_byte, file_start
//   run_out   out  red, green, blue, alpha, has_alpha, repeat_count,
//                  last_run, error_code, width_px, height_px
//
// one byte per cycle sustained while run_out is not stalled; a taken byte
// is parsed from the input register and its result goes to the result register
// synchronous active high rst returns the parser to header byte zero
// a stalled run_out holds its word and stops the parse step; byte_in takes a
// byte while the input register is empty or its byte steps in the same cycle
`timescale 1ns / 1ps
module tga_pixel_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  tpsd_in_if.sink    byte_in,
  tpsd_out_if.source run_out
);
  import tpsd_pkg::*;

  logic       word_valid;
  byte_word_t word;
  logic       free;
  logic       step;
  logic       res_valid;
  run_word_t  res;

  assign step = word_valid && free;

  tpsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .step       (step),
    .word_valid (word_valid),
    .word       (word)
  );

  tpsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  tpsd_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (step && res_valid),
    .res     (res),
    .free    (free),
    .run_out (run_out)
  );

endmodule
